>>> rtl/sgb_pkg.sv
// ----------------------------------------------------------------------------
// sgb_pkg
// shared constants, types and helpers of the separable gaussian blur
// ----------------------------------------------------------------------------
package sgb_pkg;

  localparam int PIX_W          = 8;
  localparam int COEF_W         = 16;
  localparam int DIM_W          = 11;
  localparam int VERT_W         = 20;
  localparam int NUM_COEF       = 6;
  localparam int HEIGHT_CAP     = 1024;
  localparam int TAG_W          = 5;
  localparam int REG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam int DEF_MAX_RADIUS = 5;
  localparam int DEF_MAX_WIDTH  = 1024;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_CENTER = 3'd2,
    REG_OFF1   = 3'd3,
    REG_OFF2   = 3'd4,
    REG_OFF3   = 3'd5,
    REG_OFF4   = 3'd6,
    REG_OFF5   = 3'd7
  } reg_idx_e;

  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_arr_t;

  // one line store read issued by the sequencer
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] col;
    logic [TAG_W-1:0] row;
  } issue_t;

  // weight of kernel tap idx, distances past the last register weigh zero
  function automatic logic [COEF_W-1:0] tap_weight(input logic [TAG_W-1:0] idx,
                                                   input int radius,
                                                   input coef_arr_t coefs);
    int tap_dist;
    logic [COEF_W-1:0] wt;
    tap_dist = int'(idx) - radius;
    if (tap_dist < 0) tap_dist = -tap_dist;
    wt = '0;
    for (int i = 0; i < NUM_COEF; i++) begin
      if (tap_dist == i) wt = coefs[i];
    end
    return wt;
  endfunction

endpackage

>>> rtl/sgb_line_mem.sv
// ----------------------------------------------------------------------------
// sgb_line_mem
// ring of stored rgb pixels, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sgb_line_mem #(
  parameter int DEPTH = 11269,
  parameter int AW    = 14,
  parameter int DW    = 24
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/sgb_filter.sv
// ----------------------------------------------------------------------------
// sgb_filter
// vertical then horizontal multiply-accumulate pipeline over the read stream
// ----------------------------------------------------------------------------
module sgb_filter #(
  parameter int MAX_RADIUS = sgb_pkg::DEF_MAX_RADIUS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sgb_pkg::coef_arr_t                   coefs_i,
  input  sgb_pkg::issue_t                      issue_i,
  input  logic [3*sgb_pkg::PIX_W-1:0]          rd_data_i,
  output logic                                 done_o,
  output logic [3*sgb_pkg::PIX_W-1:0]          result_o
);

  localparam int PW        = sgb_pkg::PIX_W;
  localparam int CW        = sgb_pkg::COEF_W;
  localparam int COEF_BITS = sgb_pkg::COEF_W;
  localparam int VW        = sgb_pkg::VERT_W;
  localparam int TGW       = sgb_pkg::TAG_W;
  localparam int TAPS      = 2 * MAX_RADIUS + 1;
  localparam int PROD_W    = CW + PW;
  localparam int VACC_W    = PROD_W + $clog2(TAPS);
  localparam int HPROD_W   = CW + VW;
  localparam int HACC_W    = HPROD_W + $clog2(TAPS);
  localparam int VSHIFT    = COEF_BITS - 8;
  localparam int HSHIFT    = COEF_BITS + 8;
  localparam logic [VACC_W:0] VHALF =
    (VSHIFT > 0) ? ((VACC_W+1)'(1) << (VSHIFT > 0 ? VSHIFT - 1 : 0)) : '0;
  localparam logic [HACC_W:0] HHALF = (HACC_W+1)'(1) << (HSHIFT - 1);
  localparam logic [VACC_W:0] VMAX  = (VACC_W+1)'((64'd1 << VW) - 64'd1);
  localparam logic [HACC_W:0] PMAX  = (HACC_W+1)'((1 << PW) - 1);
  localparam logic [TGW-1:0]  LAST  = TGW'(TAPS - 1);

  // read data arrives in the cycle after the issue
  sgb_pkg::issue_t s0_q;
  logic                  v1_q;
  logic [TGW-1:0]        t1_q, d1_q;
  logic [PROD_W-1:0]     prod_q [3];
  logic [VACC_W-1:0]     acc_q  [3];
  logic                  l2_q;
  logic [TGW-1:0]        t2_q;
  logic [VW-1:0]         vert_q [3];
  logic                  l3_q;
  logic [TGW-1:0]        t3_q;
  logic [HPROD_W-1:0]    hprod_q [3];
  logic                  l4_q;
  logic [TGW-1:0]        t4_q;
  logic [HACC_W-1:0]     hacc_q [3];
  logic                  l5_q;
  logic [PW-1:0]         res_q [3];
  logic                  done_q;

  logic [CW-1:0]         row_wt, col_wt;

  assign row_wt = sgb_pkg::tap_weight(s0_q.row, MAX_RADIUS, coefs_i);
  assign col_wt = sgb_pkg::tap_weight(t3_q, MAX_RADIUS, coefs_i);

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q   <= '0;
      v1_q   <= 1'b0;
      l2_q   <= 1'b0;
      l3_q   <= 1'b0;
      l4_q   <= 1'b0;
      l5_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s0_q   <= issue_i;
      v1_q   <= s0_q.valid;
      l2_q   <= v1_q && (d1_q == LAST);
      l3_q   <= l2_q;
      l4_q   <= l3_q;
      l5_q   <= l4_q && (t4_q == LAST);
      done_q <= l5_q;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    t1_q <= s0_q.col;
    d1_q <= s0_q.row;
    t2_q <= t1_q;
    t3_q <= t2_q;
    t4_q <= t3_q;
    for (int ch = 0; ch < 3; ch++) begin
      logic [VACC_W:0] vr;
      logic [HACC_W:0] hr;
      vr = ({1'b0, acc_q[ch]} + VHALF) >> VSHIFT;
      hr = ({1'b0, hacc_q[ch]} + HHALF) >> HSHIFT;
      if (s0_q.valid) begin
        prod_q[ch] <= row_wt * rd_data_i[ch*PW +: PW];
      end
      if (v1_q) begin
        acc_q[ch] <= (d1_q == '0) ? VACC_W'(prod_q[ch])
                                  : acc_q[ch] + VACC_W'(prod_q[ch]);
      end
      if (l2_q) begin
        vert_q[ch] <= (vr > VMAX) ? VW'(VMAX) : vr[VW-1:0];
      end
      if (l3_q) begin
        hprod_q[ch] <= col_wt * vert_q[ch];
      end
      if (l4_q) begin
        hacc_q[ch] <= (t4_q == '0) ? HACC_W'(hprod_q[ch])
                                   : hacc_q[ch] + HACC_W'(hprod_q[ch]);
      end
      if (l5_q) begin
        res_q[ch] <= (hr > PMAX) ? PW'(PMAX) : hr[PW-1:0];
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = {res_q[2], res_q[1], res_q[0]};

endmodule

>>> rtl/separable_gaussian_blur.sv
// ----------------------------------------------------------------------------
// separable_gaussian_blur
// rgb gaussian blur over a line store ring with clamped borders
// ----------------------------------------------------------------------------
// Pixels enter in raster order and are kept in a ring of (2R+1) lines plus R
// pixels. Output k leaves after input item k + R*W + R; once the last pixel
// is in, drain items (tuser high) push the remaining outputs out. An item that
// produces no output leaves the block idle and ready for the next item. An
// item that produces an output holds the input while the block splits the
// output index serially into row and column, reduces the row base into the
// ring and reads the window from the single read port of the line store one
// pixel per cycle, then waits for the filter result. A finished output waits
// in the output register while the next item is already taken. Kernel weights
// are Q0.16; the user must write them only while the block is idle, the block
// itself does not enforce it. R is MAX_RADIUS.
// ----------------------------------------------------------------------------
module separable_gaussian_blur #(
  parameter int MAX_RADIUS = sgb_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = sgb_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,   // red_in, green_in, blue_in
  input  logic                           s_axis_tuser,   // func: drain item when high
  // result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,   // red_out, green_out, blue_out
  output logic                           m_axis_tlast,   // frame_last
  // register writes
  input  logic                           cfg_we_i,
  input  logic [sgb_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PW        = sgb_pkg::PIX_W;
  localparam int DW        = sgb_pkg::DIM_W;
  localparam int CW        = sgb_pkg::COEF_W;
  localparam int TGW       = sgb_pkg::TAG_W;
  localparam int TAPS      = 2 * MAX_RADIUS + 1;
  localparam int LS_DEPTH  = TAPS * MAX_WIDTH + MAX_RADIUS;
  localparam int AW        = $clog2(LS_DEPTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int MAX_TOTAL = sgb_pkg::HEIGHT_CAP * MAX_WIDTH;
  localparam int CNT_W     = $clog2(MAX_TOTAL + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int QB        = $clog2(MAX_TOTAL / LS_DEPTH + 1);
  localparam int MW        = CNT_W + AW + 1;
  localparam int SCW       = $clog2(CNT_W + 1);
  localparam logic [TGW-1:0] LAST = TGW'(TAPS - 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_MOD   = 7'b0001000,
    ST_BASE  = 7'b0010000,
    ST_ISSUE = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  // configuration
  logic [DW-1:0]      width_q, height_q;
  sgb_pkg::coef_arr_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DW'(1024);
      height_q <= DW'(1024);
      coef_q   <= '0;
      coef_q[0] <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sgb_pkg::REG_WIDTH:  width_q   <= cfg_data_i[DW-1:0];
        sgb_pkg::REG_HEIGHT: height_q  <= cfg_data_i[DW-1:0];
        sgb_pkg::REG_CENTER: coef_q[0] <= cfg_data_i[CW-1:0];
        sgb_pkg::REG_OFF1:   coef_q[1] <= cfg_data_i[CW-1:0];
        sgb_pkg::REG_OFF2:   coef_q[2] <= cfg_data_i[CW-1:0];
        sgb_pkg::REG_OFF3:   coef_q[3] <= cfg_data_i[CW-1:0];
        sgb_pkg::REG_OFF4:   coef_q[4] <= cfg_data_i[CW-1:0];
        sgb_pkg::REG_OFF5:   coef_q[5] <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes, out-of-range values saturate
  logic [WW-1:0] eff_w;
  logic [DW-1:0] eff_h;
  logic [CNT_W-1:0] total, lead;

  always_comb begin
    if (width_q == '0) eff_w = WW'(1);
    else if (32'(width_q) > 32'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(width_q);
    if (height_q == '0) eff_h = DW'(1);
    else if (32'(height_q) > 32'(sgb_pkg::HEIGHT_CAP)) eff_h = DW'(sgb_pkg::HEIGHT_CAP);
    else eff_h = height_q;
  end

  // frame size and output lead follow the registers at once
  assign total = CNT_W'(eff_w * eff_h);
  assign lead  = CNT_W'(MAX_RADIUS * 32'(eff_w) + MAX_RADIUS);

  // sequencer state
  state_e            state_q;
  logic [CNT_W-1:0]  items_q, emitted_q;
  logic [AW-1:0]     wr_ptr_q;
  logic [SCW-1:0]    cnt_q;
  logic [CNT_W-1:0]  num_q;        // dividend, then quotient
  logic [WW-1:0]     rem_q;
  logic [DW-1:0]     y_q;
  logic [WW-1:0]     x_q;
  logic [MW-1:0]     mod_q;
  logic [AW-1:0]     a0_q, addr_q;
  logic [TGW-1:0]    t_q, d_q;
  logic              m_valid_q, m_last_q;
  logic [3*PW-1:0]   m_data_q;

  logic              in_acc, in_frame, wr_en;
  logic              filt_done;
  logic [3*PW-1:0]   filt_res;
  logic [3*PW-1:0]   rd_data;
  sgb_pkg::issue_t   issue;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_frame      = items_q < total;
  assign wr_en         = in_acc && in_frame && !s_axis_tuser;

  // restoring division step of the output index by the width
  logic [WW:0] rem_sh, rem_dif;
  assign rem_sh  = {rem_q, num_q[CNT_W-1]};
  assign rem_dif = rem_sh - (WW+1)'(eff_w);

  // first row of the window, clamped at the top edge
  logic [DW-1:0] r0;
  assign r0 = (32'(y_q) >= MAX_RADIUS) ? y_q - DW'(MAX_RADIUS) : '0;

  // ring reduction of the row base by shifted copies of the depth
  logic [MW-1:0] mod_sub;
  assign mod_sub = MW'(LS_DEPTH) << cnt_q;

  // column start address and row step for the read sequence
  logic [TGW-1:0] t_next;
  logic [AW-1:0]  base;
  logic [WW-1:0]  col_c;
  logic [AW:0]    col_sum, row_sum;
  logic           row_step;
  logic [AW-1:0]  col_addr, row_addr;
  int             xt, ru;

  always_comb begin
    t_next = (state_q == ST_BASE) ? '0 : t_q + TGW'(1);
    base   = (state_q == ST_BASE) ? mod_q[AW-1:0] : a0_q;
    xt     = int'(x_q) + int'(t_next) - MAX_RADIUS;
    if (xt < 0) col_c = '0;
    else if (xt > int'(eff_w) - 1) col_c = eff_w - WW'(1);
    else col_c = WW'(xt);
    col_sum  = (AW+1)'(base) + (AW+1)'(col_c);
    col_addr = (col_sum >= (AW+1)'(LS_DEPTH)) ? AW'(col_sum - (AW+1)'(LS_DEPTH))
                                              : col_sum[AW-1:0];
    // the next row moves only while both rows lie inside the image
    ru       = int'(y_q) + int'(d_q) - MAX_RADIUS;
    row_step = (ru >= 0) && (ru < int'(eff_h) - 1);
    row_sum  = (AW+1)'(addr_q) + (row_step ? (AW+1)'(eff_w) : '0);
    row_addr = (row_sum >= (AW+1)'(LS_DEPTH)) ? AW'(row_sum - (AW+1)'(LS_DEPTH))
                                              : row_sum[AW-1:0];
  end

  logic [CNT_W-1:0] k_next;
  logic             out_free, out_load;
  assign k_next   = emitted_q + CNT_W'(1);
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (state_q == ST_OUT) && (cnt_q == SCW'(1)) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      items_q   <= '0;
      emitted_q <= '0;
      wr_ptr_q  <= '0;
      cnt_q     <= '0;
      t_q       <= '0;
      d_q       <= '0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready && !out_load) m_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && !(in_frame && s_axis_tuser)) begin
            if ((items_q >= lead) && (emitted_q >= total)) begin
              // frame already complete, start over without output
              items_q   <= '0;
              emitted_q <= '0;
              wr_ptr_q  <= '0;
            end else begin
              items_q <= items_q + CNT_W'(1);
              if (in_frame) begin
                wr_ptr_q <= (wr_ptr_q == AW'(LS_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
              end
              if (items_q >= lead) begin
                cnt_q   <= SCW'(CNT_W - 1);
                state_q <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q - SCW'(1);
          if (cnt_q == '0) state_q <= ST_MUL;
        end
        ST_MUL: begin
          cnt_q   <= SCW'(QB - 1);
          state_q <= ST_MOD;
        end
        ST_MOD: begin
          cnt_q <= cnt_q - SCW'(1);
          if (cnt_q == '0) state_q <= ST_BASE;
        end
        ST_BASE: begin
          t_q     <= '0;
          d_q     <= '0;
          state_q <= ST_ISSUE;
        end
        ST_ISSUE: begin
          if (d_q == LAST) begin
            d_q <= '0;
            t_q <= t_next;
            if (t_q == LAST) state_q <= ST_OUT;
          end else begin
            d_q <= d_q + TGW'(1);
          end
        end
        ST_OUT: begin
          // the filter result lands well after the last read; done marks it
          if (out_load) begin
            cnt_q     <= '0;
            m_valid_q <= 1'b1;
            m_last_q  <= k_next >= total;
            state_q   <= ST_IDLE;
            if (k_next >= total) begin
              items_q   <= '0;
              emitted_q <= '0;
              wr_ptr_q  <= '0;
            end else begin
              emitted_q <= k_next;
            end
          end else if (filt_done) begin
            cnt_q <= SCW'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers of the sequencer
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      num_q <= emitted_q;
      rem_q <= '0;
    end
    case (state_q)
      ST_DIV: begin
        if (rem_sh >= (WW+1)'(eff_w)) begin
          rem_q <= rem_dif[WW-1:0];
          num_q <= {num_q[CNT_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[WW-1:0];
          num_q <= {num_q[CNT_W-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          y_q <= (rem_sh >= (WW+1)'(eff_w)) ? {num_q[DW-2:0], 1'b1}
                                            : {num_q[DW-2:0], 1'b0};
          x_q <= (rem_sh >= (WW+1)'(eff_w)) ? rem_dif[WW-1:0] : rem_sh[WW-1:0];
        end
      end
      ST_MUL:  mod_q <= MW'(r0 * eff_w);
      ST_MOD: begin
        if (mod_q >= mod_sub) mod_q <= mod_q - mod_sub;
      end
      ST_BASE: begin
        a0_q   <= mod_q[AW-1:0];
        addr_q <= col_addr;
      end
      ST_ISSUE: begin
        addr_q <= (d_q == LAST) ? col_addr : row_addr;
      end
      ST_OUT: begin
        if (out_load) m_data_q <= filt_res;
      end
      default: ;
    endcase
  end

  assign issue.valid = (state_q == ST_ISSUE);
  assign issue.col   = t_q;
  assign issue.row   = d_q;

  sgb_line_mem #(
    .DEPTH (LS_DEPTH),
    .AW    (AW),
    .DW    (3 * PW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_ptr_q),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (issue.valid),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_data)
  );

  sgb_filter #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_filter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .coefs_i   (coef_q),
    .issue_i   (issue),
    .rd_data_i (rd_data),
    .done_o    (filt_done),
    .result_o  (filt_res)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the rgb separable gaussian blur
// ----------------------------------------------------------------------------
// Frames of random pixels are streamed in raster order, each followed by the
// drain items that push the remaining outputs out. A behavioral blur inside
// the bench tracks the pixel ring and both counters and predicts every output
// pixel and its frame_last flag. Sizes and kernel weights are reprogrammed
// between frames once the block has gone idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAD        = sgb_pkg::DEF_MAX_RADIUS;
  localparam int TAPS       = 2 * RAD + 1;
  localparam int LINE_MAX   = sgb_pkg::DEF_MAX_WIDTH;
  localparam int RING_DEPTH = TAPS * LINE_MAX + RAD;
  localparam int IDLE_LIMIT = 10000;  // cycles without any handshake
  localparam int LONG_HOLD  = 3000;   // one long receiver stall
  localparam int SETTLE     = 200;    // settling wait after the last output
  localparam int RAND_ITEMS = 600;

  // input item: drain flag travels on tuser, pixel on tdata
  typedef struct packed {
    logic        drain;
    logic [23:0] px;     // red [7:0], green [15:8], blue [23:16]
  } stim_t;

  typedef struct packed {
    logic [23:0] px;
    logic        last;
  } blur_t;

  typedef logic [5:0][15:0] kern_t;  // [0] center, [i] weight at distance i

  typedef struct packed {
    bit          reprog;
    logic [10:0] w;
    logic [10:0] h;
    kern_t       k;
    stim_t       it;
    bit          typed;
    blur_t       want;
  } dir_row_t;

  localparam kern_t K_CENTER = {80'd0, 16'hFFFF};
  localparam kern_t K_FULL   = {6{16'hFFFF}};

  logic clk_i = 1'b0;
  logic rst_ni;

  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // red_in, green_in, blue_in
  logic        s_axis_tuser;   // func: drain item when high
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;   // red_out, green_out, blue_out
  logic        m_axis_tlast;   // frame_last
  logic                           cfg_we_i;
  logic [sgb_pkg::REG_IDX_W-1:0]  cfg_idx_i;
  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data_i;

  separable_gaussian_blur i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // blur predictor: its own pixel ring, counters and register copies
  // --------------------------------------------------------------------------
  logic [23:0] pix_ring [RING_DEPTH];
  int unsigned taken_cnt, emitted_cnt;
  logic [10:0] img_w = 11'd1024;
  logic [10:0] img_h = 11'd1024;
  kern_t       kern  = K_CENTER;
  int          mismatches = 0;

  function automatic int unsigned clip_dim(logic [10:0] v, int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic int clamp_index(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned kernel_weight(int d);
    if (d < 0) d = -d;
    return (d < 6) ? longint'(kern[d]) : 0;
  endfunction

  // returns 1 when the item yields an output pixel
  function automatic bit blur_step(input stim_t it, output blur_t res);
    int unsigned w, h, total, lead, n, k;
    int y, x, c, r;
    longint unsigned acc;
    longint unsigned vcol [TAPS][3];
    logic [23:0] p;
    w = clip_dim(img_w, LINE_MAX);
    h = clip_dim(img_h, sgb_pkg::HEIGHT_CAP);
    total = w * h;
    lead = RAD * w + RAD;
    res = '0;
    if (taken_cnt < total) begin
      if (it.drain) return 0;  // drain while pixels still expected: ignored
      pix_ring[taken_cnt % RING_DEPTH] = it.px;
    end
    n = taken_cnt;
    taken_cnt++;
    if (n < lead) return 0;
    if (emitted_cnt >= total) begin
      taken_cnt = 0;
      emitted_cnt = 0;
      return 0;
    end
    k = emitted_cnt;
    y = int'(k / w);
    x = int'(k % w);
    // vertical pass, one column of the window per horizontal tap
    for (int t = 0; t < TAPS; t++) begin
      c = clamp_index(x + t - RAD, int'(w) - 1);
      for (int ch = 0; ch < 3; ch++) begin
        acc = 0;
        for (int d = 0; d < TAPS; d++) begin
          r = clamp_index(y + d - RAD, int'(h) - 1);
          p = pix_ring[(r * int'(w) + c) % RING_DEPTH];
          acc += kernel_weight(d - RAD) * p[8*ch +: 8];
        end
        acc = (acc + 64'd128) >> 8;
        vcol[t][ch] = (acc > 64'hFFFFF) ? 64'hFFFFF : acc;
      end
    end
    // horizontal pass, rounded and saturated to 8 bits
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      for (int t = 0; t < TAPS; t++) acc += kernel_weight(t - RAD) * vcol[t][ch];
      acc = (acc + (64'd1 << 23)) >> 24;
      res.px[8*ch +: 8] = (acc > 255) ? 8'hFF : acc[7:0];
    end
    if (k + 1 >= total) begin
      res.last = 1'b1;
      taken_cnt = 0;
      emitted_cnt = 0;
    end else begin
      emitted_cnt = k + 1;
    end
    return 1;
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  blur_t expected_px_q [$];
  int    burst_left;

  // offer one item in bursts with random gaps, predict once it is taken
  task automatic send_item(input stim_t it, input bit typed, input blur_t want);
    int gap;
    blur_t res;
    bit got;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.px;
    s_axis_tuser  <= it.drain;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    got = blur_step(it, res);
    if (typed) expected_px_q.push_back(want);
    else if (got) expected_px_q.push_back(res);
  endtask

  // wait for the last output plus some settling before touching registers
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_px_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // write all eight registers back to back, enable lowered once at the end
  task automatic program_blur(input logic [10:0] w, input logic [10:0] h, input kern_t k);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sgb_pkg::REG_WIDTH;
    cfg_data_i <= sgb_pkg::CFG_DATA_W'(w);
    @(posedge clk_i);
    cfg_idx_i  <= sgb_pkg::REG_HEIGHT;
    cfg_data_i <= sgb_pkg::CFG_DATA_W'(h);
    @(posedge clk_i);
    for (int i = 0; i < 6; i++) begin
      cfg_idx_i  <= sgb_pkg::reg_idx_e'(sgb_pkg::REG_CENTER + i);
      cfg_data_i <= k[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    img_w = w;
    img_h = h;
    kern  = k;
  endtask

  function automatic stim_t rand_pixel(bit drain);
    stim_t s;
    s.drain = drain;
    s.px = 24'($urandom);
    // now and then pin channels to the extremes
    if ($urandom_range(0, 7) == 0) s.px = {$urandom_range(0, 1) ? 8'hFF : 8'h00,
                                          $urandom_range(0, 1) ? 8'hFF : 8'h00,
                                          $urandom_range(0, 1) ? 8'hFF : 8'h00};
    return s;
  endfunction

  // one whole frame: pixels with stray drains, then the flush items,
  // some of which are pixels past the end; returns items that count
  task automatic run_frame(output int counted);
    int unsigned w, h;
    w = clip_dim(img_w, LINE_MAX);
    h = clip_dim(img_h, sgb_pkg::HEIGHT_CAP);
    counted = 0;
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(rand_pixel(1'b1), 1'b0, '0);
      send_item(rand_pixel(1'b0), 1'b0, '0);
      counted++;
    end
    for (int unsigned i = 0; i < RAD * w + RAD; i++) begin
      send_item(rand_pixel($urandom_range(0, 4) != 0), 1'b0, '0);
      counted++;
    end
  endtask

  function automatic kern_t rand_kernel();
    kern_t k;
    case ($urandom_range(0, 3))
      0: k = {$urandom, $urandom, $urandom};
      1: begin
        // bell shaped, weights falling off with distance
        k[0] = 16'($urandom_range(4000, 24000));
        for (int i = 1; i < 6; i++) k[i] = 16'(k[i-1] * $urandom_range(30, 95) / 100);
      end
      2: for (int i = 0; i < 6; i++) k[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: begin
        k = '0;
        k[0] = 16'($urandom);
        k[$urandom_range(1, 5)] = 16'($urandom);
      end
    endcase
    return k;
  endfunction

  dir_row_t dir_tab [23];

  initial begin
    int counted, rand_items;

    // directed: two 1x1 frames, the first with zero sizes saturating to one
    dir_tab[0]  = '{1'b1, 11'd0, 11'd0, K_CENTER, '{1'b1, 24'h0}, 1'b0, '0}; // stray drain
    dir_tab[1]  = '{1'b0, 11'd0, 11'd0, K_CENTER, '{1'b0, 24'hFFFFFF}, 1'b0, '0};
    for (int i = 2; i < 11; i++)
      dir_tab[i] = '{1'b0, 11'd0, 11'd0, K_CENTER, '{1'b1, 24'h0}, 1'b0, '0};
    // center tap only passes the pixel through
    dir_tab[11] = '{1'b0, 11'd0, 11'd0, K_CENTER, '{1'b1, 24'h0}, 1'b1,
                    '{24'hFFFFFF, 1'b1}};
    // all taps at full weight saturate every nonzero channel
    dir_tab[12] = '{1'b1, 11'd1, 11'd1, K_FULL, '{1'b0, 24'h80FF00}, 1'b0, '0};
    for (int i = 13; i < 22; i++)
      dir_tab[i] = '{1'b0, 11'd1, 11'd1, K_FULL, '{1'b1, 24'h0}, 1'b0, '0};
    dir_tab[14] = '{1'b0, 11'd1, 11'd1, K_FULL, '{1'b0, 24'h123456}, 1'b0, '0}; // past end
    dir_tab[22] = '{1'b0, 11'd1, 11'd1, K_FULL, '{1'b1, 24'h0}, 1'b1,
                    '{24'hFFFF00, 1'b1}};

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= sgb_pkg::REG_WIDTH;
    cfg_data_i    <= '0;
    burst_left    = 0;
    taken_cnt     = 0;
    emitted_cnt   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].reprog) program_blur(dir_tab[i].w, dir_tab[i].h, dir_tab[i].k);
      send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
    end

    // tallest frame, above the height cap
    program_blur(11'd1, 11'd2047, rand_kernel());
    run_frame(counted);

    // random small frames
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      program_blur(($urandom_range(0, 15) == 0) ? 11'd0 : 11'($urandom_range(1, 12)),
                   ($urandom_range(0, 15) == 0) ? 11'd0 : 11'($urandom_range(1, 6)),
                   rand_kernel());
      run_frame(counted);
      rand_items += counted;
    end

    s_axis_tvalid <= 1'b0;
    while (expected_px_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // output side: stall pattern, one long hold, and the checker
  // --------------------------------------------------------------------------
  int results_seen  = 0;
  int hold_left     = 0;
  bit held_long     = 1'b0;
  int rx_mode       = 0;
  int rx_left       = 0;

  always @(posedge clk_i) begin
    blur_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_px_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output pixel %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = expected_px_q.pop_front();
        if (m_axis_tdata[7:0] !== want.px[7:0] || m_axis_tdata[15:8] !== want.px[15:8] ||
            m_axis_tdata[23:16] !== want.px[23:16] || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected rgb %h last %b, got rgb %h last %b",
                     want.px, want.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!held_long && results_seen >= 100) begin
      // long back-pressure so the block fills and stalls its input
      held_long = 1'b1;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(5, 60);
      end
      rx_left--;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // watchdog on cycles with no handshake and no register write
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i ||
        !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
